/* hdl/cksharp_pkg.sv */
package cksharp_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_CHANNELS = 4;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int RLEN_W       = ADDR_W + 1;
    localparam int CH_IDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PIX_W        = 8;
    localparam int DIM_W        = 12;
    localparam int CHN_W        = 3;
    localparam int ACC_W        = 12;

    localparam logic [DIM_W-1:0] WIDTH_RESET    = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET   = 12'd480;
    localparam logic [CHN_W-1:0] CHANNELS_RESET = 3'd3;
    localparam logic [DIM_W-1:0] DIM_MIN        = 12'd3;

    typedef enum logic [1:0] {
        REG_WIDTH    = 2'd0,
        REG_HEIGHT   = 2'd1,
        REG_CHANNELS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                sel;
        logic                has_out;
        logic                inner;
        logic                last_row;
        logic                last_elem;
        logic [CH_IDX_W-1:0] ch_idx;
    } item_ctl_t;

endpackage

/* hdl/cross_kernel_image_sharpen.sv */
// Pipeline: an input beat is registered with its line-store reads, then its result
// in the output register. Throughput: one input beat per cycle while m_tready holds;
// a last-row beat gives two result beats; the input stalls until the second is taken.
// Reset: position counters and row-store select clear, registers return to
// width 640, height 480, channels 3; line stores are not cleared.
module cross_kernel_image_sharpen
    import cksharp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] sample
    input  logic             s_tuser,   // [0] start_of_frame
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] value
    output logic             m_tlast,
    output logic             m_tuser    // [0] last_of_run
);

    item_ctl_t         ctl;
    logic              accept;
    logic [ADDR_W-1:0] addr_centre;
    logic [ADDR_W-1:0] addr_right;
    logic              wr_en_a;
    logic              wr_en_b;
    logic [PIX_W-1:0]  a_centre, a_right;
    logic [PIX_W-1:0]  b_centre, b_right;

    assign accept = s_tvalid && s_tready;

    cksharp_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .accept         (accept),
        .start_of_frame (s_tuser),
        .ctl            (ctl),
        .addr_centre    (addr_centre),
        .addr_right     (addr_right),
        .wr_en_a        (wr_en_a),
        .wr_en_b        (wr_en_b)
    );

    cksharp_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (PIX_W)
    ) u_store_a (
        .aclk      (aclk),
        .wr_en     (wr_en_a),
        .wr_addr   (addr_centre),
        .wr_data   (s_tdata),
        .rd_en     (accept),
        .rd_addr_0 (addr_centre),
        .rd_addr_1 (addr_right),
        .rd_data_0 (a_centre),
        .rd_data_1 (a_right)
    );

    cksharp_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (PIX_W)
    ) u_store_b (
        .aclk      (aclk),
        .wr_en     (wr_en_b),
        .wr_addr   (addr_centre),
        .wr_data   (s_tdata),
        .rd_en     (accept),
        .rd_addr_0 (addr_centre),
        .rd_addr_1 (addr_right),
        .rd_data_0 (b_centre),
        .rd_data_1 (b_right)
    );

    cksharp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .sample       (s_tdata),
        .ctl          (ctl),
        .a_centre     (a_centre),
        .a_right      (a_right),
        .b_centre     (b_centre),
        .b_right      (b_right),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_value      (m_tdata),
        .m_last_frame (m_tlast),
        .m_last_run   (m_tuser)
    );

endmodule

/* hdl/cksharp_ram.sv */
module cksharp_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_0,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_1,
    output logic [WIDTH-1:0]         rd_data_0,
    output logic [WIDTH-1:0]         rd_data_1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_0 <= mem[rd_addr_0];
            rd_data_1 <= mem[rd_addr_1];
        end
    end

endmodule

/* hdl/cksharp_ctrl.sv */
module cksharp_ctrl
    import cksharp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    input  logic              accept,
    input  logic              start_of_frame,
    output item_ctl_t         ctl,
    output logic [ADDR_W-1:0] addr_centre,
    output logic [ADDR_W-1:0] addr_right,
    output logic              wr_en_a,
    output logic              wr_en_b
);

    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [CHN_W-1:0]  channels_reg, channels_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] elem_reg, elem_next;
    logic              sel_reg, sel_next;

    logic [DIM_W-1:0]  w_c;
    logic [DIM_W-1:0]  h_c;
    logic [CHN_W-1:0]  ch_c;
    logic [RLEN_W-1:0] row_len;
    logic [DIM_W-1:0]  r;
    logic [ADDR_W-1:0] e;
    logic [RLEN_W-1:0] e_ext;
    logic [RLEN_W-1:0] ch_ext;

    always_comb begin
        width_next    = width_reg;
        height_next   = height_reg;
        channels_next = channels_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:    width_next    = cfg_data;
                REG_HEIGHT:   height_next   = cfg_data;
                REG_CHANNELS: channels_next = cfg_data[CHN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg < DIM_MIN) begin
            w_c = DIM_MIN;
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            w_c = DIM_W'(MAX_WIDTH);
        end else begin
            w_c = width_reg;
        end
        h_c = (height_reg < DIM_MIN) ? DIM_MIN : height_reg;
        if (channels_reg == '0) begin
            ch_c = CHN_W'(1);
        end else if (channels_reg > CHN_W'(MAX_CHANNELS)) begin
            ch_c = CHN_W'(MAX_CHANNELS);
        end else begin
            ch_c = channels_reg;
        end
    end

    assign row_len = RLEN_W'(w_c) * RLEN_W'(ch_c);
    assign ch_ext  = RLEN_W'(ch_c);
    assign r       = start_of_frame ? '0 : row_reg;
    assign e       = start_of_frame ? '0 : elem_reg;
    assign e_ext   = RLEN_W'(e);

    always_comb begin
        ctl.sel       = sel_reg;
        ctl.has_out   = (r != '0);
        ctl.last_row  = (r >= h_c - DIM_W'(1));
        ctl.last_elem = (e_ext + RLEN_W'(1) >= row_len);
        ctl.inner     = (r >= DIM_W'(2)) && (r < h_c) && (e_ext >= ch_ext)
                        && (e_ext + ch_ext < row_len);
        ctl.ch_idx    = CH_IDX_W'(ch_c - CHN_W'(1));
    end

    assign addr_centre = e;
    assign addr_right  = ADDR_W'(e_ext + ch_ext);
    assign wr_en_a     = accept && sel_reg;
    assign wr_en_b     = accept && !sel_reg;

    always_comb begin
        row_next  = row_reg;
        elem_next = elem_reg;
        sel_next  = sel_reg;
        if (accept) begin
            if (ctl.last_elem) begin
                elem_next = '0;
                sel_next  = !sel_reg;
                row_next  = ctl.last_row ? '0 : r + DIM_W'(1);
            end else begin
                elem_next = e + ADDR_W'(1);
                row_next  = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            channels_reg <= CHANNELS_RESET;
            row_reg      <= '0;
            elem_reg     <= '0;
            sel_reg      <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            channels_reg <= channels_next;
            row_reg      <= row_next;
            elem_reg     <= elem_next;
            sel_reg      <= sel_next;
        end
    end

endmodule

/* hdl/cksharp_core.sv */
module cksharp_core
    import cksharp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] sample,
    input  item_ctl_t        ctl,
    input  logic [PIX_W-1:0] a_centre,
    input  logic [PIX_W-1:0] a_right,
    input  logic [PIX_W-1:0] b_centre,
    input  logic [PIX_W-1:0] b_right,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_value,
    output logic             m_last_frame,
    output logic             m_last_run
);

    logic             v1_reg, v1_next;
    item_ctl_t        ctl1_reg;
    logic [PIX_W-1:0] sample1_reg;
    logic [PIX_W-1:0] hist_reg [MAX_CHANNELS];

    logic             v2_reg, v2_next;
    logic             beat2_reg, beat2_next;
    logic [PIX_W-1:0] value2_reg;
    logic             last_row2_reg;
    logic             last_elem2_reg;

    logic             accept;
    logic             adv1;
    logic             st2_free;
    logic             final2;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] left;
    logic [ACC_W-1:0] acc;
    logic [PIX_W-1:0] result;

    assign final2   = !last_row2_reg || beat2_reg;
    assign st2_free = !v2_reg || (m_ready && final2);
    assign adv1     = v1_reg && (!ctl1_reg.has_out || st2_free);
    assign s_ready  = !v1_reg || adv1;
    assign accept   = s_valid && s_ready;

    assign centre = ctl1_reg.sel ? b_centre : a_centre;
    assign right  = ctl1_reg.sel ? b_right  : a_right;
    assign up     = ctl1_reg.sel ? a_centre : b_centre;
    assign left   = hist_reg[ctl1_reg.ch_idx];

    always_comb begin
        acc = ACC_W'({centre, 2'b00}) + ACC_W'(centre) - ACC_W'(left) - ACC_W'(right)
              - ACC_W'(up) - ACC_W'(sample1_reg);
        if (!ctl1_reg.inner || acc[ACC_W-1]) begin
            result = '0;
        end else if (acc > ACC_W'(255)) begin
            result = 8'd255;
        end else begin
            result = acc[PIX_W-1:0];
        end
    end

    always_comb begin
        v1_next = v1_reg;
        if (accept) begin
            v1_next = 1'b1;
        end else if (adv1) begin
            v1_next = 1'b0;
        end
    end

    always_comb begin
        v2_next    = v2_reg;
        beat2_next = beat2_reg;
        if (adv1 && ctl1_reg.has_out) begin
            v2_next    = 1'b1;
            beat2_next = 1'b0;
        end else if (v2_reg && m_ready) begin
            if (final2) begin
                v2_next = 1'b0;
            end else begin
                beat2_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            beat2_reg <= 1'b0;
        end else begin
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            beat2_reg <= beat2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctl1_reg    <= ctl;
            sample1_reg <= sample;
        end
        if (adv1) begin
            hist_reg[0] <= centre;
            for (int i = 1; i < MAX_CHANNELS; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
        if (adv1 && ctl1_reg.has_out) begin
            value2_reg     <= result;
            last_row2_reg  <= ctl1_reg.last_row;
            last_elem2_reg <= ctl1_reg.last_elem;
        end
    end

    assign m_valid      = v2_reg;
    assign m_value      = beat2_reg ? '0 : value2_reg;
    assign m_last_frame = beat2_reg && last_elem2_reg;
    assign m_last_run   = beat2_reg || !last_row2_reg;

endmodule
